>>> sv/vrh_pkg.sv
// vrh_pkg: shared types for the volume ratio histogram block
// controller state encoding and the command and status groups between
// vrh_ctrl and vrh_datapath; no dependencies
`timescale 1ns / 1ps

package vrh_pkg;

  localparam int GROUPS = 12;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_RESP,
    S_INIT,
    S_DIV,
    S_MRD,
    S_MWR
  } state_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic div_init;
    logic div_step;
    logic mem_rd;
    logic mem_wr;
    logic clear;
    logic resp;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic sample_ok;
    logic div_last;
    logic clr_last;
  } status_t;

endpackage

>>> sv/vrh_ctrl.sv
// vrh_ctrl: sequencer for the volume ratio histogram block
// issues command words to vrh_datapath and follows its status; uses vrh_pkg
`timescale 1ns / 1ps

module vrh_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  vrh_pkg::status_t status,
  output vrh_pkg::cmd_t    cmd
);

  vrh_pkg::state_t state_r;
  vrh_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vrh_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    case (state_r)
      vrh_pkg::S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clr_last) begin
          state_nxt = vrh_pkg::S_IDLE;
        end
      end
      vrh_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = vrh_pkg::S_EVAL;
        end
      end
      vrh_pkg::S_EVAL: begin
        cmd.eval = 1'b1;
        if (status.is_read) begin
          cmd.mem_rd = 1'b1;
          state_nxt  = vrh_pkg::S_RESP;
        end else if (status.sample_ok) begin
          state_nxt = vrh_pkg::S_INIT;
        end else begin
          state_nxt = vrh_pkg::S_IDLE;
        end
      end
      vrh_pkg::S_RESP: begin
        cmd.resp  = 1'b1;
        state_nxt = vrh_pkg::S_IDLE;
      end
      vrh_pkg::S_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = vrh_pkg::S_DIV;
      end
      vrh_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_nxt = vrh_pkg::S_MRD;
        end
      end
      vrh_pkg::S_MRD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = vrh_pkg::S_MWR;
      end
      vrh_pkg::S_MWR: begin
        cmd.mem_wr = 1'b1;
        state_nxt  = vrh_pkg::S_IDLE;
      end
      default: begin
        state_nxt = vrh_pkg::S_CLEAR;
      end
    endcase
  end

endmodule

>>> sv/vrh_datapath.sv
// vrh_datapath: input capture, group pick, restoring ratio divider,
// bin count memory with read-modify-write, group totals and result registers
// driven by vrh_ctrl through vrh_pkg::cmd_t; uses vrh_pkg
`timescale 1ns / 1ps

module vrh_datapath #(
  parameter int NUM_BINS    = 50,
  parameter int COUNT_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  vrh_pkg::cmd_t    cmd,
  output vrh_pkg::status_t status,
  input  logic             in_kind,
  input  logic             in_quad_face,
  input  logic [31:0]      in_volume_a,
  input  logic [31:0]      in_volume_b,
  input  logic [2:0]       in_type_a,
  input  logic [2:0]       in_type_b,
  input  logic [3:0]       in_read_group,
  input  logic [5:0]       in_read_bin,
  output logic             out_valid,
  output logic [3:0]       out_group,
  output logic [5:0]       out_bin,
  output logic [31:0]      out_bin_count,
  output logic [31:0]      out_group_total
);

  localparam int DEPTH = vrh_pkg::GROUPS * NUM_BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(NUM_BINS + 1);
  localparam int SW    = $clog2(NW);
  localparam int BW    = $clog2(NUM_BINS);
  localparam int RW    = 31 + NW;
  localparam int XW    = AW + 4;

  localparam logic [2:0] T_TET   = 3'd0;
  localparam logic [2:0] T_PYR   = 3'd1;
  localparam logic [2:0] T_PRISM = 3'd2;
  localparam logic [2:0] T_HEX   = 3'd3;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  function automatic logic pair_is(input logic [2:0] a, input logic [2:0] b,
                                   input logic [2:0] p, input logic [2:0] q);
    pair_is = (a == p && b == q) || (a == q && b == p);
  endfunction

  // returns {hit, group}
  function automatic logic [4:0] pick_group(input logic quad, input logic [2:0] a,
                                            input logic [2:0] b);
    logic [4:0] r;
    r = '0;
    if (!quad) begin
      if      (pair_is(a, b, T_TET,   T_TET))   r = {1'b1, 4'd0};
      else if (pair_is(a, b, T_TET,   T_PYR))   r = {1'b1, 4'd1};
      else if (pair_is(a, b, T_TET,   T_PRISM)) r = {1'b1, 4'd2};
      else if (pair_is(a, b, T_PYR,   T_PYR))   r = {1'b1, 4'd3};
      else if (pair_is(a, b, T_PYR,   T_PRISM)) r = {1'b1, 4'd4};
      else if (pair_is(a, b, T_PRISM, T_PRISM)) r = {1'b1, 4'd5};
    end else begin
      if      (pair_is(a, b, T_PYR,   T_PYR))   r = {1'b1, 4'd6};
      else if (pair_is(a, b, T_PYR,   T_PRISM)) r = {1'b1, 4'd7};
      else if (pair_is(a, b, T_PRISM, T_PRISM)) r = {1'b1, 4'd8};
      else if (pair_is(a, b, T_PYR,   T_HEX))   r = {1'b1, 4'd9};
      else if (pair_is(a, b, T_PRISM, T_HEX))   r = {1'b1, 4'd10};
      else if (pair_is(a, b, T_HEX,   T_HEX))   r = {1'b1, 4'd11};
    end
    pick_group = r;
  endfunction

  // captured word
  logic             kind_r;
  logic             quad_r;
  logic [31:0]      vol_a_r;
  logic [31:0]      vol_b_r;
  logic [2:0]       type_a_r;
  logic [2:0]       type_b_r;
  logic [3:0]       rgrp_r;
  logic [5:0]       rbin_r;

  logic [3:0]       grp_r;
  logic [30:0]      lo_r;
  logic [30:0]      hi_r;
  logic [RW-1:0]    rem_r;
  logic [RW-1:0]    div_r;
  logic [NW-1:0]    quo_r;
  logic [SW-1:0]    step_r;
  logic [AW-1:0]    clr_addr_r;

  logic [COUNT_WIDTH-1:0] mem [DEPTH];
  logic [COUNT_WIDTH-1:0] rdata_r;
  logic [COUNT_WIDTH-1:0] tot_r [vrh_pkg::GROUPS];

  logic             out_valid_r;
  logic [3:0]       out_group_r;
  logic [5:0]       out_bin_r;
  logic [31:0]      out_bin_count_r;
  logic [31:0]      out_group_total_r;

  logic             pos_a;
  logic             pos_b;
  logic [4:0]       pick;
  logic             rd_in_range;
  logic [RW-1:0]    rem_sub;
  logic             rem_ge;
  logic [BW-1:0]    bin_sel;
  logic [XW-1:0]    addr_full;
  logic [AW-1:0]    addr;
  logic [63:0]      cnt_ext;
  logic [63:0]      tot_ext;
  logic [COUNT_WIDTH-1:0] tot_sel;

  assign pos_a = !vol_a_r[31] && (vol_a_r != 32'd0);
  assign pos_b = !vol_b_r[31] && (vol_b_r != 32'd0);
  assign pick  = pick_group(quad_r, type_a_r, type_b_r);

  assign rd_in_range = (rgrp_r < 4'(vrh_pkg::GROUPS)) &&
                       (32'(rbin_r) < 32'(NUM_BINS));

  assign rem_ge  = rem_r >= div_r;
  assign rem_sub = rem_r - div_r;

  // equal volumes give a quotient of NUM_BINS, clamp to the top bin
  assign bin_sel = (32'(quo_r) > 32'(NUM_BINS - 1)) ? BW'(NUM_BINS - 1) : BW'(quo_r);

  always_comb begin
    if (kind_r) begin
      addr_full = XW'(rgrp_r) * XW'(NUM_BINS) + XW'(rbin_r);
    end else begin
      addr_full = XW'(grp_r) * XW'(NUM_BINS) + XW'(bin_sel);
    end
  end
  assign addr = addr_full[AW-1:0];

  assign status.is_read   = kind_r;
  assign status.sample_ok = pos_a && pos_b && pick[4];
  assign status.div_last  = (step_r == '0);
  assign status.clr_last  = (32'(clr_addr_r) == 32'(DEPTH - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_kind;
      quad_r   <= in_quad_face;
      vol_a_r  <= in_volume_a;
      vol_b_r  <= in_volume_b;
      type_a_r <= in_type_a;
      type_b_r <= in_type_b;
      rgrp_r   <= in_read_group;
      rbin_r   <= in_read_bin;
    end
    if (cmd.eval) begin
      grp_r <= pick[3:0];
      if (vol_a_r < vol_b_r) begin
        lo_r <= vol_a_r[30:0];
        hi_r <= vol_b_r[30:0];
      end else begin
        lo_r <= vol_b_r[30:0];
        hi_r <= vol_a_r[30:0];
      end
    end
    if (cmd.div_init) begin
      rem_r  <= RW'(lo_r) * RW'(NUM_BINS);
      div_r  <= RW'(hi_r) << (NW - 1);
      quo_r  <= '0;
      step_r <= SW'(NW - 1);
    end else if (cmd.div_step) begin
      if (rem_ge) begin
        rem_r <= rem_sub;
      end
      quo_r  <= {quo_r[NW-2:0], rem_ge};
      div_r  <= div_r >> 1;
      step_r <= step_r - 1'b1;
    end
  end

  // clear sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear && !status.clr_last) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // bin count memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_addr_r] <= '0;
    end else if (cmd.mem_wr) begin
      mem[addr] <= (rdata_r == CNT_MAX) ? rdata_r : rdata_r + 1'b1;
    end
    if (cmd.mem_rd && (!kind_r || rd_in_range)) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vrh_pkg::GROUPS; i++) begin
        tot_r[i] <= '0;
      end
    end else if (cmd.mem_wr && tot_r[grp_r] != CNT_MAX) begin
      tot_r[grp_r] <= tot_r[grp_r] + 1'b1;
    end
  end

  assign tot_sel = tot_r[rgrp_r];
  assign cnt_ext = rd_in_range ? 64'(rdata_r) : 64'd0;
  assign tot_ext = rd_in_range ? 64'(tot_sel) : 64'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.resp;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resp) begin
      out_group_r       <= rgrp_r;
      out_bin_r         <= rbin_r;
      out_bin_count_r   <= cnt_ext[31:0];
      out_group_total_r <= tot_ext[31:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_group       = out_group_r;
  assign out_bin         = out_bin_r;
  assign out_bin_count   = out_bin_count_r;
  assign out_group_total = out_group_total_r;

endmodule

>>> sv/volume_ratio_histogram.sv
// volume_ratio_histogram: top level, twelve saturating histograms of cell
// volume ratios; instantiates vrh_ctrl and vrh_datapath, uses vrh_pkg
//
//   channel  ports                          handshake
//   input    in_*                           start high while busy low
//   result   out_*                          out_valid, one cycle, no stall
//
// a read word passes the eval and resp states; its result strobes from the out_valid register
// a sample word passes eval, divider init, the restoring divider steps and the bin
// read-modify-write; the divider gives one bit a cycle over clog2(NUM_BINS + 1) quotient bits
// a dropped sample goes from eval straight back to idle
// after reset busy stays high while the clear state zeroes all 12 * NUM_BINS bins
`timescale 1ns / 1ps

module volume_ratio_histogram #(
  parameter int NUM_BINS    = 50,
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_kind,
  input  logic        in_quad_face,
  input  logic [31:0] in_volume_a,
  input  logic [31:0] in_volume_b,
  input  logic [2:0]  in_type_a,
  input  logic [2:0]  in_type_b,
  input  logic [3:0]  in_read_group,
  input  logic [5:0]  in_read_bin,
  output logic        out_valid,
  output logic [3:0]  out_group,
  output logic [5:0]  out_bin,
  output logic [31:0] out_bin_count,
  output logic [31:0] out_group_total
);

  vrh_pkg::cmd_t    cmd;
  vrh_pkg::status_t status;

  vrh_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  vrh_datapath #(
    .NUM_BINS    (NUM_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_kind         (in_kind),
    .in_quad_face    (in_quad_face),
    .in_volume_a     (in_volume_a),
    .in_volume_b     (in_volume_b),
    .in_type_a       (in_type_a),
    .in_type_b       (in_type_b),
    .in_read_group   (in_read_group),
    .in_read_bin     (in_read_bin),
    .out_valid       (out_valid),
    .out_group       (out_group),
    .out_bin         (out_bin),
    .out_bin_count   (out_bin_count),
    .out_group_total (out_group_total)
  );

endmodule
